@@ rtl/dpf_pkg.sv @@
package dpf_pkg;

    localparam int PORT_BITS = 16;
    localparam int PORT_COUNT = 1 << PORT_BITS;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_FLAG_WR = 1'b1;

    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [7:0] PROTO_SCTP = 8'd132;

    localparam logic [7:0] TCP_HDR_LEN = 8'd20;
    localparam logic [7:0] UDP_HDR_LEN = 8'd8;
    localparam logic [7:0] SCTP_HDR_LEN = 8'd12;

    localparam logic [7:0] ETH_LEN = 8'd14;
    localparam logic [7:0] IPV4_MIN_END = 8'd34;
    localparam logic [7:0] COUNT_MAX = 8'd255;

    localparam logic [7:0] POS_TYPE_HI = 8'd12;
    localparam logic [7:0] POS_TYPE_LO = 8'd13;
    localparam logic [7:0] POS_IHL = 8'd14;
    localparam logic [7:0] POS_PROTO = 8'd23;
    localparam logic [7:0] POS_SRC_FIRST = 8'd26;
    localparam logic [7:0] POS_SRC_LAST = 8'd29;
    localparam logic [7:0] POS_DST_FIRST = 8'd30;
    localparam logic [7:0] POS_DST_LAST = 8'd33;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

    // one queued word: a flag table write or a frame verdict waiting on its lookup
    typedef struct packed {
        logic        is_write;
        logic        flag;
        logic        cand;
        logic [15:0] port;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] l4_sport;
        logic [7:0]  proto;
        logic [63:0] time_stamp;
    } t_q_entry;

endpackage

@@ rtl/ipv4_dest_port_drop_filter_core.sv @@
// a frame's verdict word enters the queue at the edge that accepts its last byte; o_valid follows its registered lookup
// throughput: one byte or flag write per cycle while o_stall is low, one verdict per frame
// the 4-word queue between capture and table lookup lets either side stall alone
// after reset the flag table is swept clear, one port per cycle across all 65536 ports,
// and o_stall stays high until the sweep ends
module ipv4_dest_port_drop_filter_core
    import dpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_port_number,
    input  logic        i_port_flag,
    input  logic [63:0] i_time_now,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_drop,
    output logic [31:0] o_source_address,
    output logic [31:0] o_dest_address,
    output logic [15:0] o_source_port,
    output logic [15:0] o_dest_port,
    output logic [7:0]  o_protocol_number,
    output logic [63:0] o_event_time
);

    logic     accept;
    logic     push;
    logic     q_full;
    logic     q_valid;
    logic     pop;
    logic     clearing;
    t_q_entry push_entry;
    t_q_entry head_entry;

    assign o_stall = q_full || clearing;
    assign accept = i_valid && !o_stall;

    dpf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_req_type   (i_req_type),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .i_port_number(i_port_number),
        .i_port_flag  (i_port_flag),
        .i_time_now   (i_time_now),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    dpf_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (push_entry),
        .o_full (q_full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_data (head_entry)
    );

    dpf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_data         (head_entry),
        .o_pop            (pop),
        .o_clearing       (clearing),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_drop           (o_drop),
        .o_source_address (o_source_address),
        .o_dest_address   (o_dest_address),
        .o_source_port    (o_source_port),
        .o_dest_port      (o_dest_port),
        .o_protocol_number(o_protocol_number),
        .o_event_time     (o_event_time)
    );

endmodule

@@ rtl/dpf_ram.sv @@
module dpf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/dpf_front.sv @@
module dpf_front
    import dpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_req_type,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_port_number,
    input  logic        i_port_flag,
    input  logic [63:0] i_time_now,
    output logic        o_push,
    output t_q_entry    o_entry
);

    logic [7:0]  r_byte_count, n_byte_count;
    logic [15:0] r_frame_type, n_frame_type;
    logic [3:0]  r_header_words, n_header_words;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_src_addr, n_src_addr;
    logic [31:0] r_dst_addr, n_dst_addr;
    logic [15:0] r_sport, n_sport;
    logic [15:0] r_dport, n_dport;

    logic [7:0] pos;
    logic [7:0] l4_pos;
    logic [7:0] hdr_len;
    logic       proto_ok;
    logic       cand;
    logic       is_byte;

    assign pos = r_byte_count;
    assign is_byte = (i_req_type == REQ_BYTE);

    always_comb begin
        n_frame_type = r_frame_type;
        n_header_words = r_header_words;
        n_proto = r_proto;
        n_src_addr = r_src_addr;
        n_dst_addr = r_dst_addr;
        n_sport = r_sport;
        n_dport = r_dport;
        if (pos == POS_TYPE_HI || pos == POS_TYPE_LO) begin
            n_frame_type = {r_frame_type[7:0], i_data_byte};
        end
        if (pos == POS_IHL) begin
            n_header_words = i_data_byte[3:0];
        end
        if (pos == POS_PROTO) begin
            n_proto = i_data_byte;
        end
        if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) begin
            n_src_addr = {r_src_addr[23:0], i_data_byte};
        end
        if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) begin
            n_dst_addr = {r_dst_addr[23:0], i_data_byte};
        end
        l4_pos = ETH_LEN + {2'b00, n_header_words, 2'b00};
        if (pos == l4_pos || pos == l4_pos + 8'd1) begin
            n_sport = {r_sport[7:0], i_data_byte};
        end
        if (pos == l4_pos + 8'd2 || pos == l4_pos + 8'd3) begin
            n_dport = {r_dport[7:0], i_data_byte};
        end
        n_byte_count = (r_byte_count == COUNT_MAX) ? r_byte_count : r_byte_count + 8'd1;
    end

    always_comb begin
        proto_ok = 1'b1;
        unique case (n_proto)
            PROTO_TCP:  hdr_len = TCP_HDR_LEN;
            PROTO_UDP:  hdr_len = UDP_HDR_LEN;
            PROTO_SCTP: hdr_len = SCTP_HDR_LEN;
            default: begin
                hdr_len = 8'd0;
                proto_ok = 1'b0;
            end
        endcase
        cand = proto_ok && (n_byte_count >= IPV4_MIN_END) && (n_frame_type == ETH_IPV4)
            && (n_byte_count >= l4_pos + hdr_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_frame_type <= '0;
            r_header_words <= '0;
            r_proto <= '0;
            r_src_addr <= '0;
            r_dst_addr <= '0;
            r_sport <= '0;
            r_dport <= '0;
        end else if (i_accept && is_byte) begin
            if (i_last_byte) begin
                r_byte_count <= '0;
                r_frame_type <= '0;
                r_header_words <= '0;
                r_proto <= '0;
                r_src_addr <= '0;
                r_dst_addr <= '0;
                r_sport <= '0;
                r_dport <= '0;
            end else begin
                r_byte_count <= n_byte_count;
                r_frame_type <= n_frame_type;
                r_header_words <= n_header_words;
                r_proto <= n_proto;
                r_src_addr <= n_src_addr;
                r_dst_addr <= n_dst_addr;
                r_sport <= n_sport;
                r_dport <= n_dport;
            end
        end
    end

    assign o_push = i_accept && (!is_byte || i_last_byte);

    always_comb begin
        o_entry.is_write = !is_byte;
        o_entry.flag = i_port_flag;
        o_entry.cand = cand;
        o_entry.port = is_byte ? n_dport : i_port_number;
        o_entry.src_addr = n_src_addr;
        o_entry.dst_addr = n_dst_addr;
        o_entry.l4_sport = n_sport;
        o_entry.proto = n_proto;
        o_entry.time_stamp = i_time_now;
    end

endmodule

@@ rtl/dpf_queue.sv @@
module dpf_queue
    import dpf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_data,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_valid,
    output t_q_entry o_data
);

    t_q_entry r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr;
    logic [Q_PTR_BITS-1:0] r_rd_ptr;
    logic [Q_PTR_BITS:0]   r_count;

    assign o_full = (r_count == (Q_PTR_BITS+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_PTR_BITS+1)'(Q_DEPTH)) else $error("queue count overflow");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0 && !o_full) |-> (r_wr_ptr != r_rd_ptr))
        else $error("queue pointers disagree with count");
`endif

endmodule

@@ rtl/dpf_back.sv @@
module dpf_back
    import dpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_q_entry    i_q_data,
    output logic        o_pop,
    output logic        o_clearing,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_drop,
    output logic [31:0] o_source_address,
    output logic [31:0] o_dest_address,
    output logic [15:0] o_source_port,
    output logic [15:0] o_dest_port,
    output logic [7:0]  o_protocol_number,
    output logic [63:0] o_event_time
);

    logic                 r_clearing;
    logic [PORT_BITS-1:0] r_clr_addr;
    logic                 r_b_valid;
    t_q_entry             r_b_entry;

    logic                 b_free;
    logic                 lookup;
    logic                 ram_we;
    logic [PORT_BITS-1:0] ram_waddr;
    logic                 ram_wdata;
    logic                 ram_rdata;
    logic                 hit;

    assign b_free = !r_b_valid || !i_stall;
    assign o_pop = !r_clearing && i_q_valid && (i_q_data.is_write || b_free);
    assign lookup = o_pop && !i_q_data.is_write;

    always_comb begin
        if (r_clearing) begin
            ram_we = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = 1'b0;
        end else begin
            ram_we = o_pop && i_q_data.is_write;
            ram_waddr = i_q_data.port[PORT_BITS-1:0];
            ram_wdata = i_q_data.flag;
        end
    end

    dpf_ram #(
        .WIDTH(1),
        .DEPTH(PORT_COUNT)
    ) u_flags (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (lookup),
        .i_raddr(i_q_data.port[PORT_BITS-1:0]),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == '1) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (lookup) begin
            r_b_valid <= 1'b1;
        end else if (!i_stall) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lookup) begin
            r_b_entry <= i_q_data;
        end
    end

    assign hit = r_b_entry.cand && ram_rdata;

    assign o_clearing = r_clearing;
    assign o_valid = r_b_valid;
    assign o_drop = hit;
    assign o_source_address = hit ? r_b_entry.src_addr : '0;
    assign o_dest_address = hit ? r_b_entry.dst_addr : '0;
    assign o_source_port = hit ? r_b_entry.l4_sport : '0;
    assign o_dest_port = hit ? r_b_entry.port : '0;
    assign o_protocol_number = hit ? r_b_entry.proto : '0;
    assign o_event_time = hit ? r_b_entry.time_stamp : '0;

`ifndef NO_ASSERTIONS
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_pop) else $error("queue popped during table clear");
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && i_stall) |=> (r_b_valid && $stable(ram_rdata)))
        else $error("stalled result lost its lookup data");
    a_lookup_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lookup |-> b_free) else $error("lookup issued over a waiting result");
`endif

endmodule
